// ----- design/bcpe_pkg.sv -----
// ----------------------------------------------------------------------------
// bcpe_pkg
// Shared widths, register indexes, control word format and microcode ROM
// for the Bezier point evaluator.
// ----------------------------------------------------------------------------
package bcpe_pkg;

    localparam int T_W        = 17;
    localparam int STEP_W     = 16;
    localparam int POINT_W    = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int CNT_W      = 3;
    localparam int UU_W       = 34;
    localparam int OPB_W      = 18;
    localparam int WP_W       = UU_W + OPB_W;
    localparam int W_W        = 31;
    localparam int Q_SHIFT    = 30;
    localparam int PC_W       = 5;

    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_A     = 3'd2;

    localparam logic [CNT_W-1:0] POINT_COUNT_RST = 3'd4;

    localparam logic [PC_W-1:0] ENTRY_M0 = 5'd1;
    localparam logic [PC_W-1:0] ENTRY_M1 = 5'd4;
    localparam logic [PC_W-1:0] ENTRY_M2 = 5'd8;
    localparam logic [PC_W-1:0] ENTRY_M3 = 5'd14;

    typedef enum logic [1:0] {ASEL_U, ASEL_T, ASEL_UU, ASEL_TT} t_asel;
    typedef enum logic       {BSEL_U, BSEL_T} t_bsel;
    typedef enum logic [1:0] {WSRC_ONE, WSRC_U, WSRC_T, WSRC_PROD} t_wsrc;
    typedef enum logic       {JMP_NEXT, JMP_DEGREE} t_jmp;

    typedef struct packed {
        logic       wmul;
        t_asel      asel;
        t_bsel      bsel;
        logic [1:0] bk;
        logic       save_uu;
        logic       save_tt;
        logic       wload;
        t_wsrc      wsrc;
        logic       mac;
        logic [1:0] pidx;
        logic       acc;
        t_jmp       jmp;
        logic       last;
    } t_uword;

    typedef struct packed {
        logic       start;
        logic [1:0] degree;
        t_uword     uw;
    } t_seq_ctl;

    localparam t_uword UW_NOP = '0;

    // weight product -> r_wp, r_wp -> scaled weight r_w, r_w * point -> r_mp, r_mp -> acc
    function automatic t_uword uc_rom(input logic [PC_W-1:0] a);
        t_uword w;
        w = UW_NOP;
        w.bk = 2'd1;
        unique case (a)
            5'd0: begin
                w.jmp = JMP_DEGREE;
            end
            // one point
            5'd1: begin
                w.wload = 1'b1; w.wsrc = WSRC_ONE;
            end
            5'd2: begin
                w.mac = 1'b1; w.pidx = 2'd0;
            end
            5'd3: begin
                w.acc = 1'b1; w.last = 1'b1;
            end
            // linear
            5'd4: begin
                w.wload = 1'b1; w.wsrc = WSRC_U;
            end
            5'd5: begin
                w.wload = 1'b1; w.wsrc = WSRC_T;
                w.mac = 1'b1; w.pidx = 2'd0;
            end
            5'd6: begin
                w.mac = 1'b1; w.pidx = 2'd1; w.acc = 1'b1;
            end
            5'd7: begin
                w.acc = 1'b1; w.last = 1'b1;
            end
            // quadratic
            5'd8: begin
                w.wmul = 1'b1; w.asel = ASEL_U; w.bsel = BSEL_U;
            end
            5'd9: begin
                w.wmul = 1'b1; w.asel = ASEL_U; w.bsel = BSEL_T; w.bk = 2'd2;
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
            end
            5'd10: begin
                w.wmul = 1'b1; w.asel = ASEL_T; w.bsel = BSEL_T;
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
                w.mac = 1'b1; w.pidx = 2'd0;
            end
            5'd11: begin
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
                w.mac = 1'b1; w.pidx = 2'd1; w.acc = 1'b1;
            end
            5'd12: begin
                w.mac = 1'b1; w.pidx = 2'd2; w.acc = 1'b1;
            end
            5'd13: begin
                w.acc = 1'b1; w.last = 1'b1;
            end
            // cubic
            5'd14: begin
                w.wmul = 1'b1; w.asel = ASEL_U; w.bsel = BSEL_U;
            end
            5'd15: begin
                w.save_uu = 1'b1;
                w.wmul = 1'b1; w.asel = ASEL_T; w.bsel = BSEL_T;
            end
            5'd16: begin
                w.save_tt = 1'b1;
                w.wmul = 1'b1; w.asel = ASEL_UU; w.bsel = BSEL_U;
            end
            5'd17: begin
                w.wmul = 1'b1; w.asel = ASEL_UU; w.bsel = BSEL_T; w.bk = 2'd3;
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
            end
            5'd18: begin
                w.wmul = 1'b1; w.asel = ASEL_TT; w.bsel = BSEL_U; w.bk = 2'd3;
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
                w.mac = 1'b1; w.pidx = 2'd0;
            end
            5'd19: begin
                w.wmul = 1'b1; w.asel = ASEL_TT; w.bsel = BSEL_T;
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
                w.mac = 1'b1; w.pidx = 2'd1; w.acc = 1'b1;
            end
            5'd20: begin
                w.wload = 1'b1; w.wsrc = WSRC_PROD;
                w.mac = 1'b1; w.pidx = 2'd2; w.acc = 1'b1;
            end
            5'd21: begin
                w.mac = 1'b1; w.pidx = 2'd3; w.acc = 1'b1;
            end
            5'd22: begin
                w.acc = 1'b1; w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] uc_entry(input logic [1:0] deg);
        logic [PC_W-1:0] e;
        unique case (deg)
            2'd0:    e = ENTRY_M0;
            2'd1:    e = ENTRY_M1;
            2'd2:    e = ENTRY_M2;
            default: e = ENTRY_M3;
        endcase
        return e;
    endfunction

endpackage

// ----- design/bcpe_if.sv -----
// ----------------------------------------------------------------------------
// bcpe_if
// Valid/ready channels of the Bezier point evaluator: step items in,
// result items out, register writes.
// ----------------------------------------------------------------------------
interface bcpe_in_if import bcpe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_amount;

    modport source (output valid, output step_amount, input ready);
    modport sink   (input valid, input step_amount, output ready);
endinterface

interface bcpe_out_if import bcpe_pkg::*; #(
    parameter int COORD_WIDTH = 16
) ();
    logic                          valid;
    logic                          ready;
    logic [T_W-1:0]                param_now;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;

    modport source (output valid, output param_now, output pos_x, output pos_y,
                    output pos_z, input ready);
    modport sink   (input valid, input param_now, input pos_x, input pos_y,
                    input pos_z, output ready);
endinterface

interface bcpe_cfg_if import bcpe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/bcpe_seq.sv -----
// ----------------------------------------------------------------------------
// bcpe_seq
// Microcode sequencer: step counter, degree dispatch and the hand-off of
// the finished sums to the output register.
// ----------------------------------------------------------------------------
module bcpe_seq import bcpe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_deg,
    input  logic       i_out_free,
    output t_seq_ctl   o_ctl,
    output logic       o_busy,
    output logic       o_fin
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    logic [1:0]      r_deg;
    t_uword          w_uw;

    assign w_uw = uc_rom(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_pc    <= '0;
                        r_deg   <= i_deg;
                    end
                end
                ST_RUN: begin
                    if (w_uw.last) begin
                        r_state <= ST_FIN;
                    end else if (w_uw.jmp == JMP_DEGREE) begin
                        r_pc <= uc_entry(r_deg);
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (i_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_ctl.start  = i_start;
        o_ctl.degree = r_deg;
        o_ctl.uw     = (r_state == ST_RUN) ? w_uw : UW_NOP;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_fin  = (r_state == ST_FIN) && i_out_free;

endmodule

// ----- design/bcpe_dp.sv -----
// ----------------------------------------------------------------------------
// bcpe_dp
// Datapath: Bernstein weight multiplier, three coordinate MAC lanes and
// the round and saturate of the final sums.
// ----------------------------------------------------------------------------
module bcpe_dp import bcpe_pkg::*; #(
    parameter int MAX_POINTS  = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  t_seq_ctl                      i_ctl,
    input  logic [T_W-1:0]                i_t,
    input  logic [MAX_POINTS*POINT_W-1:0] i_points,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z
);

    localparam int CW = COORD_WIDTH;
    localparam int PW = (3 * CW > POINT_W) ? 3 * CW : POINT_W;
    localparam int MW = CW + 32;
    localparam int AW = CW + 33;
    localparam int QW = AW - Q_SHIFT + 1;

    localparam logic signed [AW:0]   RND  = (AW+1)'(2 ** (Q_SHIFT - 1));
    localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] Q_LO = ~Q_HI;

    logic [T_W-1:0]   w_u;
    logic [T_W-1:0]   w_base;
    logic [UU_W-1:0]  w_opa;
    logic [OPB_W-1:0] w_opb;
    logic [WP_W-1:0]  w_raw;
    logic [W_W-1:0]   w_wnext;
    logic [POINT_W-1:0] w_pt;
    logic [PW-1:0]      w_ext;
    logic signed [CW-1:0] w_coord [3];
    logic signed [AW:0]   w_rs    [3];
    logic signed [QW-1:0] w_q     [3];
    logic signed [CW-1:0] w_sat   [3];

    logic [UU_W-1:0]      r_uu;
    logic [UU_W-1:0]      r_tt;
    logic [WP_W-1:0]      r_wp;
    logic [W_W-1:0]       r_w;
    logic signed [MW-1:0] r_mp  [3];
    logic signed [AW-1:0] r_acc [3];

    assign w_u = T_ONE - i_t;

    always_comb begin
        case (i_ctl.uw.asel)
            ASEL_U:  w_opa = UU_W'(w_u);
            ASEL_T:  w_opa = UU_W'(i_t);
            ASEL_UU: w_opa = r_uu;
            default: w_opa = r_tt;
        endcase
        w_base = (i_ctl.uw.bsel == BSEL_T) ? i_t : w_u;
        case (i_ctl.uw.bk)
            2'd2:    w_opb = {w_base, 1'b0};
            2'd3:    w_opb = {w_base, 1'b0} + OPB_W'(w_base);
            default: w_opb = OPB_W'(w_base);
        endcase
    end

    // weight to Q1.30 for the current degree
    always_comb begin
        case (i_ctl.uw.wsrc)
            WSRC_ONE: w_raw = WP_W'(1);
            WSRC_U:   w_raw = WP_W'(w_u);
            WSRC_T:   w_raw = WP_W'(i_t);
            default:  w_raw = r_wp;
        endcase
        case (i_ctl.degree)
            2'd0:    w_wnext = W_W'(w_raw << Q_SHIFT);
            2'd1:    w_wnext = W_W'(w_raw << (Q_SHIFT - 16));
            2'd2:    w_wnext = W_W'((w_raw + WP_W'(2)) >> 2);
            default: w_wnext = W_W'((w_raw + WP_W'(2 ** 17)) >> 18);
        endcase
    end

    always_comb begin
        w_pt = '0;
        for (int k = 0; k < MAX_POINTS; k++) begin
            if (i_ctl.uw.pidx == 2'(k)) begin
                w_pt = i_points[k*POINT_W +: POINT_W];
            end
        end
        w_ext = PW'(w_pt);
        for (int c = 0; c < 3; c++) begin
            w_coord[c] = $signed(w_ext[c*CW +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.uw.wmul) begin
            r_wp <= w_opa * w_opb;
        end
        if (i_ctl.uw.save_uu) begin
            r_uu <= r_wp[UU_W-1:0];
        end
        if (i_ctl.uw.save_tt) begin
            r_tt <= r_wp[UU_W-1:0];
        end
        if (i_ctl.uw.wload) begin
            r_w <= w_wnext;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_ctl.uw.mac) begin
                r_mp[c] <= w_coord[c] * $signed({1'b0, r_w});
            end
            if (i_ctl.start) begin
                r_acc[c] <= '0;
            end else if (i_ctl.uw.acc) begin
                r_acc[c] <= r_acc[c] + AW'(r_mp[c]);
            end
        end
    end

    // round half up, then clamp to the coordinate range
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rs[c] = $signed({r_acc[c][AW-1], r_acc[c]}) + RND;
            w_q[c]  = w_rs[c][AW:Q_SHIFT];
            if (w_q[c] > Q_HI) begin
                w_sat[c] = CW'(Q_HI);
            end else if (w_q[c] < Q_LO) begin
                w_sat[c] = CW'(Q_LO);
            end else begin
                w_sat[c] = CW'(w_q[c]);
            end
        end
    end

    assign o_pos_x = w_sat[0];
    assign o_pos_y = w_sat[1];
    assign o_pos_z = w_sat[2];

endmodule

// ----- design/bezier_curve_point_evaluator.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_point_evaluator
// Advances the curve parameter by each step item and returns the parameter
// with the Bezier point of up to four control points.
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        step_amount[15:0]
//   o_out    out  valid/ready        param_now[16:0], pos_x/y/z
//   i_cfg    in   valid/ready (rdy=1) index[2:0], data[47:0]
//
// One item at a time; the microcode program, run behind the one weight
// multiplier, grows longer with the point count. Result valid in the
// same cycle that ready returns. A result waits in the output register;
// a finished sum holds in the sequencer until that register is free.
// Synchronous active-low reset.
// ----------------------------------------------------------------------------
module bezier_curve_point_evaluator import bcpe_pkg::*; #(
    parameter int MAX_POINTS  = 4,
    parameter int COORD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcpe_in_if.sink     i_in,
    bcpe_out_if.source  o_out,
    bcpe_cfg_if.sink    i_cfg
);

    logic [CNT_W-1:0]   r_point_count;
    logic               r_wrap;
    logic [POINT_W-1:0] r_points [MAX_POINTS];
    logic [T_W-1:0]     r_curve_param;

    logic                          r_ovalid;
    logic [T_W-1:0]                r_param;
    logic signed [COORD_WIDTH-1:0] r_px;
    logic signed [COORD_WIDTH-1:0] r_py;
    logic signed [COORD_WIDTH-1:0] r_pz;

    logic                          w_accept;
    logic                          w_busy;
    logic                          w_fin;
    logic                          w_out_free;
    logic [CNT_W-1:0]              w_n;
    logic [1:0]                    w_deg;
    logic [T_W:0]                  w_tsum;
    logic [T_W-1:0]                w_tnext;
    logic [MAX_POINTS*POINT_W-1:0] w_points;
    t_seq_ctl                      w_ctl;
    logic signed [COORD_WIDTH-1:0] w_px;
    logic signed [COORD_WIDTH-1:0] w_py;
    logic signed [COORD_WIDTH-1:0] w_pz;

    assign i_in.ready  = !w_busy;
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ovalid || o_out.ready;

    always_comb begin
        w_n = r_point_count;
        if (w_n == '0) begin
            w_n = CNT_W'(1);
        end
        if (w_n > CNT_W'(MAX_POINTS)) begin
            w_n = CNT_W'(MAX_POINTS);
        end
        w_deg = 2'(w_n - CNT_W'(1));

        w_tsum = {1'b0, r_curve_param} + (T_W+1)'(i_in.step_amount);
        if (w_tsum >= (T_W+1)'(T_ONE)) begin
            w_tnext = r_wrap ? '0 : T_ONE;
        end else begin
            w_tnext = w_tsum[T_W-1:0];
        end

        for (int k = 0; k < MAX_POINTS; k++) begin
            w_points[k*POINT_W +: POINT_W] = r_points[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
            r_wrap        <= 1'b0;
            r_curve_param <= '0;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_points[k] <= '0;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_POINT_COUNT) begin
                    r_point_count <= i_cfg.data[CNT_W-1:0];
                end
                if (i_cfg.index == REG_WRAP) begin
                    r_wrap <= i_cfg.data[0];
                end
                for (int k = 0; k < MAX_POINTS; k++) begin
                    if (i_cfg.index == REG_POINT_A + CFG_IDX_W'(k)) begin
                        r_points[k] <= i_cfg.data[POINT_W-1:0];
                    end
                end
            end
            if (w_accept) begin
                r_curve_param <= w_tnext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_fin) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_fin) begin
            r_param <= r_curve_param;
            r_px    <= w_px;
            r_py    <= w_py;
            r_pz    <= w_pz;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.param_now = r_param;
    assign o_out.pos_x     = r_px;
    assign o_out.pos_y     = r_py;
    assign o_out.pos_z     = r_pz;

    bcpe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_deg      (w_deg),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_busy     (w_busy),
        .o_fin      (w_fin)
    );

    bcpe_dp #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_t      (r_curve_param),
        .i_points (w_points),
        .o_pos_x  (w_px),
        .o_pos_y  (w_py),
        .o_pos_z  (w_pz)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("input ready while an item is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |-> (!r_ovalid || o_out.ready))
        else $error("result loaded over a pending item");

    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_curve_param <= T_ONE)
        else $error("curve parameter above one");

    a_param_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |=> $stable(r_curve_param))
        else $error("curve parameter moved during evaluation");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Bezier point evaluator. Step items are driven
// with random gaps and result items taken with random stalls. A scoreboard
// keeps its own copy of the curve parameter and registers, predicts each
// result item and compares it field by field. Registers are rewritten only
// when no result is outstanding.
// ----------------------------------------------------------------------------
module testbench;
    import bcpe_pkg::*;

    localparam int CW    = 16;
    localparam int LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [T_W-1:0]       param;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_curve_point;

    class point_tracker;
        logic [T_W-1:0]     t_now;
        logic [CNT_W-1:0]   count;
        logic               wrap;
        logic [POINT_W-1:0] pts[4];
        t_curve_point       due[$];
        int                 errors;

        function new();
            t_now  = '0;
            count  = POINT_COUNT_RST;
            wrap   = 1'b0;
            errors = 0;
            foreach (pts[k]) pts[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_POINT_COUNT: begin
                    count = data[CNT_W-1:0];
                end
                REG_WRAP: begin
                    wrap = data[0];
                end
                REG_SPARE_LO, REG_SPARE_HI: begin
                end
                default: begin
                    pts[idx - REG_POINT_A] = data[POINT_W-1:0];
                end
            endcase
        endfunction

        // Bernstein weight of point i for degree deg, Q30
        function longint weight(int deg, int i, logic [T_W-1:0] t);
            longint unsigned u;
            longint unsigned p;
            int              d;
            u = 65536 - longint'(t);
            p = ((deg == 3 && (i == 1 || i == 2)) ? 3 : (deg == 2 && i == 1) ? 2 : 1);
            for (int k = 0; k < deg - i; k++) p = p * u;
            for (int k = 0; k < i; k++) p = p * longint'(t);
            if (16 * deg <= Q_SHIFT) return longint'(p << (Q_SHIFT - 16 * deg));
            d = 16 * deg - Q_SHIFT;
            return longint'((p + (64'd1 << (d - 1))) >> d);
        endfunction

        function logic signed [CW-1:0] round_clip(longint s);
            longint q;
            q = (s + (64'sd1 <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
            if (q < -32768) q = -32768;
            if (q > 32767) q = 32767;
            return q[CW-1:0];
        endfunction

        function void note_step(logic [STEP_W-1:0] step_in);
            logic [T_W:0]         t_sum;
            int                   n;
            longint               w;
            longint               acc[3];
            logic signed [CW-1:0] v;
            t_curve_point         r;
            t_sum = {1'b0, t_now} + (T_W+1)'(step_in);
            if (t_sum >= {1'b0, T_ONE}) t_now = wrap ? '0 : T_ONE;
            else t_now = t_sum[T_W-1:0];
            n = count;
            if (n == 0) n = 1;
            if (n > 4) n = 4;
            foreach (acc[c]) acc[c] = 0;
            for (int i = 0; i < n; i++) begin
                w = weight(n - 1, i, t_now);
                for (int c = 0; c < 3; c++) begin
                    v = pts[i][CW*c +: CW];
                    acc[c] += longint'(v) * w;
                end
            end
            r.param = t_now;
            r.x     = round_clip(acc[0]);
            r.y     = round_clip(acc[1]);
            r.z     = round_clip(acc[2]);
            due.push_back(r);
        endfunction

        function void check_point(logic [T_W-1:0] p, logic [CW-1:0] x, logic [CW-1:0] y,
                                  logic [CW-1:0] z);
            t_curve_point e;
            if (due.size() == 0) begin
                $display("%0t: unexpected result item param_now %h", $time, p);
                errors++;
                return;
            end
            e = due.pop_front();
            if (p !== e.param) begin
                $display("%0t: param_now expected %h actual %h", $time, e.param, p);
                errors++;
            end
            if (x !== e.x) begin
                $display("%0t: pos_x expected %h actual %h", $time, e.x, x);
                errors++;
            end
            if (y !== e.y) begin
                $display("%0t: pos_y expected %h actual %h", $time, e.y, y);
                errors++;
            end
            if (z !== e.z) begin
                $display("%0t: pos_z expected %h actual %h", $time, e.z, z);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    int   stall_left;
    int   cycle_count;

    point_tracker tracker = new();

    bcpe_in_if                        in_if();
    bcpe_out_if #(.COORD_WIDTH(CW))   out_if();
    bcpe_cfg_if                       cfg_if();

    bezier_curve_point_evaluator #(
        .MAX_POINTS  (4),
        .COORD_WIDTH (CW)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("bezier_curve_point_evaluator test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            tracker.check_point(out_if.param_now, out_if.pos_x, out_if.pos_y, out_if.pos_z);
    end

    // result stalls in random bursts, started only while idle_on is set
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left   <= $urandom_range(0, 3);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic drive_step(input logic [STEP_W-1:0] step_in);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.step_amount <= step_in;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_step(step_in);
    endtask

    task automatic stop_steps();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (tracker.due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] junk_bits();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [POINT_W-1:0] rand_point();
        logic [POINT_W-1:0] p;
        case ($urandom_range(0, 7))
            0: p = {3{16'h7FFF}};
            1: p = {3{16'h8000}};
            2: p = {16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                    16'($urandom_range(0, 15))};
            default: p = junk_bits();
        endcase
        return p;
    endfunction

    function automatic logic [STEP_W-1:0] rand_step();
        logic [STEP_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = '1;
            2: s = STEP_W'($urandom_range(0, 255));
            3, 4: s = STEP_W'($urandom_range(0, 4095));
            default: s = STEP_W'($urandom);
        endcase
        return s;
    endfunction

    initial begin
        logic [CFG_DATA_W-1:0] d;
        int                    n;
        i_rst_n           = 1'b0;
        idle_on           = 1'b1;
        stall_left        = 0;
        cycle_count       = 0;
        in_if.valid       = 1'b0;
        in_if.step_amount = '0;
        out_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: four points at the origin
        drive_step(16'h0000);
        drive_step(16'h4000);
        stop_steps();
        drain();

        // extreme coordinates, clamp at the end
        write_reg(REG_POINT_A,         48'h0001_8000_7FFF);
        write_reg(REG_POINT_A + 3'd1,  48'h8000_7FFF_8000);
        write_reg(REG_POINT_A + 3'd2,  48'h7FFF_7FFF_7FFF);
        write_reg(REG_POINT_A + 3'd3,  48'h8000_8000_8000);
        drive_step(16'h0000);
        drive_step(16'h0001);
        drive_step(16'h8000);
        drive_step(16'hFFFF);
        drive_step(16'h0000);
        stop_steps();
        drain();

        // query at 1.0 with wrapping moves t to zero
        write_reg(REG_WRAP, 48'h1);
        drive_step(16'h0000);
        drive_step(16'hFFFF);
        drive_step(16'h0001);
        drive_step(16'h5555);
        stop_steps();
        drain();

        // point count zero acts as one point
        write_reg(REG_POINT_COUNT, 48'h0);
        drive_step(16'h4000);
        drive_step(16'hC000);
        stop_steps();
        drain();

        // point count above the maximum
        write_reg(REG_POINT_COUNT, 48'h7);
        drive_step(16'h1234);
        stop_steps();
        drain();
        write_reg(REG_POINT_COUNT, 48'h2);
        drive_step(16'h8000);
        stop_steps();
        drain();
        write_reg(REG_POINT_COUNT, 48'h3);
        drive_step(16'h8000);
        drive_step(16'h3000);
        stop_steps();
        drain();

        // out-of-range register indexes are ignored
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        drive_step(16'h0100);
        stop_steps();
        drain();

        for (int phase = 0; phase < 11; phase++) begin
            if (phase < 4) n = phase + 1;
            else if ($urandom_range(0, 9) == 0) n = 0;
            else if ($urandom_range(0, 8) == 0) n = $urandom_range(5, 7);
            else n = $urandom_range(1, 4);
            d = junk_bits();
            d[CNT_W-1:0] = CNT_W'(n);
            write_reg(REG_POINT_COUNT, d);
            d = junk_bits();
            if (phase < 4) d[0] = phase[0];
            write_reg(REG_WRAP, d);
            for (int k = 0; k < 4; k++) write_reg(REG_POINT_A + CFG_IDX_W'(k), rand_point());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, junk_bits());
            idle_on = (phase == 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (100) drive_step(rand_step());
            stop_steps();
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.due.size() == 0) begin
            $display("bezier_curve_point_evaluator test passed");
        end else begin
            $display("bezier_curve_point_evaluator test failed");
        end
        $finish;
    end

endmodule
